@@ design/gfeb_pkg.sv @@
package gfeb_pkg;

	// Default grid bounds.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Widths fixed by the interface.
	localparam int CFG_W   = 7;
	localparam int STEPS_W = 13;
	localparam int KIND_W  = 2;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Cell kinds as stored in the grid memory.
	localparam logic [KIND_W-1:0] K_WALL   = 2'd0;
	localparam logic [KIND_W-1:0] K_OPEN   = 2'd1;
	localparam logic [KIND_W-1:0] K_RUNNER = 2'd2;
	localparam logic [KIND_W-1:0] K_FIRE   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PLACE,
		S_DIV,
		S_SEED,
		S_POP,
		S_NREAD,
		S_NEVAL,
		S_RESULT
	} state_t;

	// Search outcome handed from the controller to the output register.
	typedef struct packed {
		logic [STEPS_W-1:0] steps;
		logic               fail;
	} result_t;

endpackage

@@ design/gfeb_ram.sv @@
module gfeb_ram import gfeb_pkg::*; #(
	parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
	parameter int W     = KIND_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/gfeb_ctrl.sv @@
module gfeb_ctrl import gfeb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW    = $clog2(MAX_ROWS),
	localparam int CW    = $clog2(MAX_COLS),
	localparam int NRW   = $clog2(MAX_ROWS + 1),
	localparam int NCW   = $clog2(MAX_COLS + 1),
	localparam int GAW   = RW + CW,
	localparam int CELLS = MAX_ROWS * MAX_COLS,
	localparam int PW    = $clog2(CELLS + 1),
	localparam int DW    = PW,
	localparam int QCAP  = 2 * CELLS + 1,
	localparam int QAW   = $clog2(QCAP),
	localparam int QEW   = RW + CW + DW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NRW-1:0]    nr_rows,
	input  logic [NCW-1:0]    nr_cols,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_busy,
	output logic              res_valid,
	output result_t           res,
	output logic              grid_we,
	output logic [GAW-1:0]    grid_waddr,
	output logic [KIND_W-1:0] grid_wdata,
	output logic              grid_re,
	output logic [GAW-1:0]    grid_raddr,
	input  logic [KIND_W-1:0] grid_rdata,
	output logic              q_we,
	output logic [QAW-1:0]    q_waddr,
	output logic [QEW-1:0]    q_wdata,
	output logic              q_re,
	output logic [QAW-1:0]    q_raddr,
	input  logic [QEW-1:0]    q_rdata
);

	localparam int QPW = $clog2(QCAP + 1);
	localparam int TW  = NCW + RW + 1;
	localparam int DCW = (RW > 1) ? $clog2(RW) : 1;
	localparam int PRW = NRW + NCW;

	state_t state_q, state_d;

	logic [PW-1:0]     pos_q;
	logic [RW:0]       r_q;
	logic [CW-1:0]     c_q;
	logic [NCW-1:0]    used_cols_q;
	logic [QPW-1:0]    head_q, tail_q;
	logic [RW-1:0]     prow_q;
	logic [CW-1:0]     pcol_q;
	logic [KIND_W-1:0] kind_q;
	logic              last_q;
	logic [1:0]        k_q;
	logic [RW-1:0]     nb_r_q;
	logic [CW-1:0]     nb_c_q;
	logic [TW-1:0]     rem_q;
	logic [RW-1:0]     quo_q;
	logic [DCW-1:0]    dcnt_q;
	logic [GAW-1:0]    clr_q;
	logic [STEPS_W-1:0] steps_q;
	logic              fail_q;

	logic              in_range, split_ok, q_room, q_nonempty;
	logic [PRW-1:0]    total;
	logic [TW-1:0]     trial, rem_next;
	logic [RW-1:0]     quo_next;
	logic [RW-1:0]     e_row, nb_r;
	logic [CW-1:0]     e_col, nb_c;
	logic [DW-1:0]     e_dist;
	logic              e_run, nb_out;
	logic [DW:0]       dist_inc;
	logic              take_cell, push_nb;
	logic [KIND_W-1:0] take_kind;

	// Load bookkeeping: is the cell inside the active grid, and is the row/column split current.
	assign total      = PRW'(nr_rows) * PRW'(nr_cols);
	assign in_range   = PRW'(pos_q) < total;
	assign split_ok   = (pos_q == '0) || (used_cols_q == nr_cols);
	assign q_room     = tail_q < QPW'(QCAP);
	assign q_nonempty = head_q < tail_q;

	// One restoring-division step per cycle to split the load position.
	always_comb begin
		trial    = TW'(nr_cols) << dcnt_q;
		rem_next = rem_q;
		quo_next = quo_q;
		if (rem_q >= trial) begin
			rem_next         = rem_q - trial;
			quo_next[dcnt_q] = 1'b1;
		end
	end

	// Fields of the queue entry being expanded.
	assign e_row    = q_rdata[RW-1:0];
	assign e_col    = q_rdata[RW+CW-1:RW];
	assign e_dist   = q_rdata[RW+CW+DW-1:RW+CW];
	assign e_run    = q_rdata[QEW-1];
	assign dist_inc = {1'b0, e_dist} + (DW+1)'(1);

	// Neighbor in direction k: down, right, up, left.
	always_comb begin
		nb_r   = e_row;
		nb_c   = e_col;
		nb_out = 1'b0;
		case (k_q)
			2'd0: begin
				nb_r   = e_row + RW'(1);
				nb_out = (NRW'(e_row) + NRW'(1)) >= nr_rows;
			end
			2'd1: begin
				nb_c   = e_col + CW'(1);
				nb_out = (NCW'(e_col) + NCW'(1)) >= nr_cols;
			end
			2'd2: begin
				nb_r   = e_row - RW'(1);
				nb_out = (e_row == '0);
			end
			2'd3: begin
				nb_c   = e_col - CW'(1);
				nb_out = (e_col == '0);
			end
			default: begin
				nb_out = 1'b0;
			end
		endcase
	end

	// Which neighbor cells a wavefront takes.
	always_comb begin
		take_cell = 1'b0;
		take_kind = K_FIRE;
		if (grid_rdata == K_OPEN) begin
			take_cell = 1'b1;
			take_kind = e_run ? K_RUNNER : K_FIRE;
		end else if (!e_run && grid_rdata == K_RUNNER) begin
			take_cell = 1'b1;
		end
	end
	assign push_nb = take_cell && q_room;

	assign res.steps = steps_q;
	assign res.fail  = fail_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory requests.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		grid_we    = 1'b0;
		grid_waddr = clr_q;
		grid_wdata = K_WALL;
		grid_re    = 1'b0;
		grid_raddr = {nb_r, nb_c};
		q_we       = 1'b0;
		q_waddr    = tail_q[QAW-1:0];
		q_wdata    = '0;
		q_re       = 1'b0;
		q_raddr    = head_q[QAW-1:0];
		case (state_q)
			S_CLEAR: begin
				grid_we = 1'b1;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				if (in_range && !split_ok) begin
					state_d = S_DIV;
				end else begin
					if (in_range) begin
						grid_we    = 1'b1;
						grid_waddr = {r_q[RW-1:0], c_q};
						grid_wdata = kind_q;
						if (kind_q == K_FIRE && q_room) begin
							q_we    = 1'b1;
							q_wdata = {1'b0, DW'(0), c_q, r_q[RW-1:0]};
						end
					end
					state_d = last_q ? S_SEED : S_IDLE;
				end
			end
			S_DIV: begin
				if (dcnt_q == '0) begin
					state_d = S_PLACE;
				end
			end
			S_SEED: begin
				q_we    = q_room;
				q_wdata = {1'b1, DW'(0), pcol_q, prow_q};
				state_d = S_POP;
			end
			S_POP: begin
				if (q_nonempty) begin
					q_re    = 1'b1;
					state_d = S_NREAD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_NREAD: begin
				if (nb_out) begin
					if (e_run) begin
						state_d = S_RESULT;
					end else if (k_q == 2'd3) begin
						state_d = S_POP;
					end
				end else begin
					grid_re = 1'b1;
					state_d = S_NEVAL;
				end
			end
			S_NEVAL: begin
				grid_waddr = {nb_r_q, nb_c_q};
				grid_wdata = take_kind;
				grid_we    = take_cell;
				q_we       = push_nb;
				q_wdata    = {e_run, DW'(dist_inc), nb_c_q, nb_r_q};
				state_d    = (k_q == 2'd3) ? S_POP : S_NREAD;
			end
			S_RESULT: begin
				if (!out_busy) begin
					res_valid = 1'b1;
					state_d   = S_CLEAR;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Datapath and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			used_cols_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			prow_q      <= '0;
			pcol_q      <= '0;
			k_q         <= '0;
			dcnt_q      <= '0;
			clr_q       <= '0;
			last_q      <= 1'b0;
			kind_q      <= K_WALL;
			rem_q       <= '0;
			quo_q       <= '0;
			nb_r_q      <= '0;
			nb_c_q      <= '0;
			steps_q     <= '0;
			fail_q      <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GAW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= in_kind;
						last_q <= in_last;
					end
				end
				S_PLACE: begin
					if (in_range && !split_ok) begin
						rem_q  <= TW'(pos_q);
						quo_q  <= '0;
						dcnt_q <= DCW'(RW - 1);
					end else if (in_range) begin
						pos_q       <= pos_q + PW'(1);
						used_cols_q <= nr_cols;
						if (kind_q == K_RUNNER) begin
							prow_q <= r_q[RW-1:0];
							pcol_q <= c_q;
						end
						if (kind_q == K_FIRE && q_room) begin
							tail_q <= tail_q + QPW'(1);
						end
						if ((NCW'(c_q) + NCW'(1)) == nr_cols) begin
							r_q <= r_q + (RW+1)'(1);
							c_q <= '0;
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == '0) begin
						r_q         <= (RW+1)'(quo_next);
						c_q         <= CW'(rem_next);
						used_cols_q <= nr_cols;
					end
				end
				S_SEED: begin
					if (q_room) begin
						tail_q <= tail_q + QPW'(1);
					end
				end
				S_POP: begin
					k_q <= '0;
					if (q_nonempty) begin
						head_q <= head_q + QPW'(1);
					end else begin
						steps_q <= '0;
						fail_q  <= 1'b1;
					end
				end
				S_NREAD: begin
					if (nb_out) begin
						k_q <= k_q + 2'd1;
						if (e_run) begin
							steps_q <= STEPS_W'(dist_inc);
							fail_q  <= 1'b0;
						end
					end else begin
						nb_r_q <= nb_r;
						nb_c_q <= nb_c;
					end
				end
				S_NEVAL: begin
					k_q <= k_q + 2'd1;
					if (push_nb) begin
						tail_q <= tail_q + QPW'(1);
					end
				end
				S_RESULT: begin
					if (!out_busy) begin
						pos_q  <= '0;
						r_q    <= '0;
						c_q    <= '0;
						head_q <= '0;
						tail_q <= '0;
						prow_q <= '0;
						pcol_q <= '0;
					end
				end
				default: begin
					clr_q <= '0;
				end
			endcase
		end
	end

	// The queue is never read past its tail.
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	// The queue never grows past its capacity.
	a_tail_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= QPW'(QCAP))
		else $error("queue tail beyond capacity");

	// Grid data is only evaluated in the cycle after its read was issued.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEVAL |-> $past(grid_re))
		else $error("neighbor evaluated without a grid read");

	// Every delivered result is followed by a clearing pass.
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> state_q == S_CLEAR && clr_q == '0)
		else $error("no clearing pass after result");

endmodule

@@ design/grid_fire_escape_bfs.sv @@
// Fire-escape grid search. Cells arrive one per request in row-major order on the
// slave stream (tdata bits 1:0 = cell kind, tlast = last cell); the request with tlast
// set starts a multi-source breadth-first search, fire cells first in load order and
// the runner last, and yields one result: the steps until the runner leaves the grid,
// or the impossible flag. A cell is accepted, then written to the grid if in range;
// after a change of cols in the middle of a grid the next cell first goes through the
// shift-subtract split of its position. The search walks the frontier queue memory:
// each queue entry is popped, then each of its four neighbors is bounds-checked and,
// if inside the grid, read from the grid memory and evaluated. After reset and after
// each result the grid memory is cleared to walls, one cell a cycle; no cell is
// accepted meanwhile, while configuration writes are always taken.
module grid_fire_escape_bfs import gfeb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [1:0] cell_kind
	input  logic             s_tlast,   // last_cell
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // [12:0] escape_steps
	output logic             m_tuser,   // impossible
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int NRW   = $clog2(MAX_ROWS + 1);
	localparam int NCW   = $clog2(MAX_COLS + 1);
	localparam int GAW   = RW + CW;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int DW    = $clog2(CELLS + 1);
	localparam int QCAP  = 2 * CELLS + 1;
	localparam int QAW   = $clog2(QCAP);
	localparam int QEW   = RW + CW + DW + 1;

	logic [CFG_W-1:0]  rows_q, cols_q;
	logic [NRW-1:0]    nr_rows;
	logic [NCW-1:0]    nr_cols;
	logic              in_ready, res_valid, out_busy;
	result_t           res;
	logic              m_tvalid_q;
	logic [STEPS_W-1:0] steps_q;
	logic              fail_q;

	logic              grid_we, grid_re;
	logic [GAW-1:0]    grid_waddr, grid_raddr;
	logic [KIND_W-1:0] grid_wdata, grid_rdata;
	logic              q_we, q_re;
	logic [QAW-1:0]    q_waddr, q_raddr;
	logic [QEW-1:0]    q_wdata, q_rdata;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
				default: rows_q <= rows_q;
			endcase
		end
	end

	// Out-of-range dimensions act as the nearest legal value.
	assign nr_rows = (rows_q == '0) ? NRW'(1) :
		(int'(rows_q) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(rows_q);
	assign nr_cols = (cols_q == '0) ? NCW'(1) :
		(int'(cols_q) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(cols_q);

	// Output register decouples the result from the downstream stall.
	assign out_busy = m_tvalid_q && !m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (res_valid) begin
			steps_q <= res.steps;
			fail_q  <= res.fail;
		end
	end
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(16 - STEPS_W)'(0), steps_q};
	assign m_tuser  = fail_q;
	assign s_tready = in_ready;

	gfeb_ctrl #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.nr_rows    (nr_rows),
		.nr_cols    (nr_cols),
		.in_valid   (s_tvalid),
		.in_kind    (s_tdata[KIND_W-1:0]),
		.in_last    (s_tlast),
		.in_ready   (in_ready),
		.out_busy   (out_busy),
		.res_valid  (res_valid),
		.res        (res),
		.grid_we    (grid_we),
		.grid_waddr (grid_waddr),
		.grid_wdata (grid_wdata),
		.grid_re    (grid_re),
		.grid_raddr (grid_raddr),
		.grid_rdata (grid_rdata),
		.q_we       (q_we),
		.q_waddr    (q_waddr),
		.q_wdata    (q_wdata),
		.q_re       (q_re),
		.q_raddr    (q_raddr),
		.q_rdata    (q_rdata)
	);

	// Grid cells, addressed by row and column.
	gfeb_ram #(
		.DEPTH(1 << GAW),
		.W    (KIND_W)
	) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.re    (grid_re),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	// Frontier queue: runner flag, distance, column, row.
	gfeb_ram #(
		.DEPTH(QCAP),
		.W    (QEW)
	) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

endmodule
